// File: sv/fdes_pkg.sv
// ----------------------------------------------------------------------------
// fdes_pkg
// Shared types and constants for the FAT directory entry scanner.
// ----------------------------------------------------------------------------
package fdes_pkg;

    localparam int unsigned ENTRY_BYTES = 32;
    localparam int unsigned NAME_BYTES  = 8;
    localparam int unsigned EXT_BYTES   = 3;

    localparam logic [7:0] BYTE_END       = 8'h00;
    localparam logic [7:0] BYTE_DELETED   = 8'hE5;
    localparam logic [7:0] BYTE_DOT       = 8'h2E;
    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_LFN_MASK  = 8'h3F;
    localparam logic [7:0] ATTR_LFN       = 8'h0F;
    localparam logic [7:0] LFN_SEQ_MASK   = 8'h1F;

    // Byte offsets inside one directory entry.
    localparam int unsigned OFS_ATTR      = 11;
    localparam int unsigned OFS_CLUS_HI   = 20;
    localparam int unsigned OFS_TIME      = 22;
    localparam int unsigned OFS_DATE      = 24;
    localparam int unsigned OFS_CLUS_LO   = 26;
    localparam int unsigned OFS_SIZE      = 28;
    localparam int unsigned LFN_LAST_BIT  = 6;

    typedef enum logic [2:0] {
        KIND_SHORT   = 3'd0,
        KIND_DELETED = 3'd1,
        KIND_LFN     = 3'd2,
        KIND_DOT     = 3'd3,
        KIND_END     = 3'd4
    } t_kind;

    typedef logic [ENTRY_BYTES-1:0][7:0] t_entry;

    typedef struct packed {
        t_kind        entry_kind;
        logic [63:0]  short_name;
        logic [3:0]   name_length;
        logic [23:0]  extension;
        logic [1:0]   extension_length;
        logic [7:0]   attributes;
        logic [31:0]  first_cluster;
        logic [31:0]  file_size;
        logic [15:0]  modified_date;
        logic [15:0]  modified_time;
        logic [4:0]   lfn_sequence;
        logic         lfn_is_last;
    } t_result;

endpackage

// File: sv/fdes_decode.sv
// ----------------------------------------------------------------------------
// fdes_decode
// Classifies one complete 32-byte directory entry and extracts its fields.
// ----------------------------------------------------------------------------
module fdes_decode (
    input  fdes_pkg::t_entry  i_entry,
    output fdes_pkg::t_result o_result
);

    fdes_pkg::t_kind kind;
    logic [3:0]      name_len;
    logic [1:0]      ext_len;
    logic [7:0]      first;

    assign first = i_entry[0];

    always_comb begin
        if (first == fdes_pkg::BYTE_END) begin
            kind = fdes_pkg::KIND_END;
        end else if (first == fdes_pkg::BYTE_DELETED) begin
            kind = fdes_pkg::KIND_DELETED;
        end else if ((i_entry[fdes_pkg::OFS_ATTR] & fdes_pkg::ATTR_LFN_MASK)
                     == fdes_pkg::ATTR_LFN) begin
            kind = fdes_pkg::KIND_LFN;
        end else if (first == fdes_pkg::BYTE_DOT) begin
            kind = fdes_pkg::KIND_DOT;
        end else begin
            kind = fdes_pkg::KIND_SHORT;
        end
    end

    // Length is one past the last byte that is not a space.
    always_comb begin
        name_len = 4'd0;
        for (int i = 0; i < fdes_pkg::NAME_BYTES; i++) begin
            if (i_entry[i] != fdes_pkg::BYTE_SPACE) begin
                name_len = 4'(i + 1);
            end
        end
        ext_len = 2'd0;
        for (int i = 0; i < fdes_pkg::EXT_BYTES; i++) begin
            if (i_entry[fdes_pkg::NAME_BYTES + i] != fdes_pkg::BYTE_SPACE) begin
                ext_len = 2'(i + 1);
            end
        end
    end

    always_comb begin
        o_result.entry_kind       = kind;
        o_result.short_name       = {i_entry[7], i_entry[6], i_entry[5], i_entry[4],
                                     i_entry[3], i_entry[2], i_entry[1], i_entry[0]};
        o_result.name_length      = name_len;
        o_result.extension        = {i_entry[10], i_entry[9], i_entry[8]};
        o_result.extension_length = ext_len;
        o_result.attributes       = i_entry[fdes_pkg::OFS_ATTR];
        o_result.first_cluster    = {i_entry[fdes_pkg::OFS_CLUS_HI + 1],
                                     i_entry[fdes_pkg::OFS_CLUS_HI],
                                     i_entry[fdes_pkg::OFS_CLUS_LO + 1],
                                     i_entry[fdes_pkg::OFS_CLUS_LO]};
        o_result.file_size        = {i_entry[fdes_pkg::OFS_SIZE + 3],
                                     i_entry[fdes_pkg::OFS_SIZE + 2],
                                     i_entry[fdes_pkg::OFS_SIZE + 1],
                                     i_entry[fdes_pkg::OFS_SIZE]};
        o_result.modified_date    = {i_entry[fdes_pkg::OFS_DATE + 1],
                                     i_entry[fdes_pkg::OFS_DATE]};
        o_result.modified_time    = {i_entry[fdes_pkg::OFS_TIME + 1],
                                     i_entry[fdes_pkg::OFS_TIME]};
        if (kind == fdes_pkg::KIND_LFN) begin
            o_result.lfn_sequence = 5'(first & fdes_pkg::LFN_SEQ_MASK);
            o_result.lfn_is_last  = first[fdes_pkg::LFN_LAST_BIT];
        end else begin
            o_result.lfn_sequence = 5'd0;
            o_result.lfn_is_last  = 1'b0;
        end
    end

endmodule

// File: sv/fat_directory_entry_scanner.sv
// ----------------------------------------------------------------------------
// fat_directory_entry_scanner
// Collects directory bytes into 32-byte entries and reports each entry.
// ----------------------------------------------------------------------------
// The scanner takes one directory byte per cycle unless it stalls the input.
// Bytes 0 to 30 of an entry are held in a byte register bank; when byte 31
// arrives, the entry is decoded in the same cycle and the result is loaded
// into the output register, so one result leaves for every 32 bytes taken and
// appears in the cycle after the last byte of its entry. Input requests are
// stalled only when a result still waits downstream and 31 bytes of another
// entry are held, even on a restart. After an end-of-directory entry, bytes
// are taken and dropped until a request with i_restart set begins a new scan.
module fat_directory_entry_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_entry_kind,
    output logic [63:0] o_short_name,
    output logic [3:0]  o_name_length,
    output logic [23:0] o_extension,
    output logic [1:0]  o_extension_length,
    output logic [7:0]  o_attributes,
    output logic [31:0] o_first_cluster,
    output logic [31:0] o_file_size,
    output logic [15:0] o_modified_date,
    output logic [15:0] o_modified_time,
    output logic [4:0]  o_lfn_sequence,
    output logic        o_lfn_is_last
);

    localparam int unsigned HELD_BYTES = fdes_pkg::ENTRY_BYTES - 1;

    logic [4:0]        r_pos;
    logic              r_ended;
    logic [7:0]        r_bytes [0:HELD_BYTES-1];
    logic              r_out_valid;
    fdes_pkg::t_result r_res;

    logic [4:0]        n_pos;
    logic              n_ended;
    logic              n_out_valid;

    logic              accept_in;
    logic              take;
    logic              emit;
    logic              last_pos;
    logic [4:0]        pos_eff;
    logic              ended_eff;
    fdes_pkg::t_entry  entry;
    fdes_pkg::t_result dec_res;

    assign last_pos = (r_pos == 5'(HELD_BYTES));
    assign o_stall  = r_out_valid && i_stall && last_pos && !r_ended;

    assign accept_in = i_valid && !o_stall;
    assign pos_eff   = i_restart ? 5'd0 : r_pos;
    assign ended_eff = i_restart ? 1'b0 : r_ended;
    assign take      = accept_in && !ended_eff;
    assign emit      = take && (pos_eff == 5'(HELD_BYTES));

    always_comb begin
        for (int i = 0; i < HELD_BYTES; i++) begin
            entry[i] = r_bytes[i];
        end
        entry[HELD_BYTES] = i_data_byte;
    end

    fdes_decode u_decode (
        .i_entry  (entry),
        .o_result (dec_res)
    );

    always_comb begin
        n_pos       = r_pos;
        n_ended     = r_ended;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (accept_in) begin
            n_ended = ended_eff;
            n_pos   = pos_eff;
        end
        if (take) begin
            n_pos = pos_eff + 5'd1;
        end
        if (emit) begin
            n_out_valid = 1'b1;
            n_ended     = (dec_res.entry_kind == fdes_pkg::KIND_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 5'd0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_ended     <= n_ended;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !emit) begin
            r_bytes[pos_eff] <= i_data_byte;
        end
        if (emit) begin
            r_res <= dec_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_entry_kind       = r_res.entry_kind;
    assign o_short_name       = r_res.short_name;
    assign o_name_length      = r_res.name_length;
    assign o_extension        = r_res.extension;
    assign o_extension_length = r_res.extension_length;
    assign o_attributes       = r_res.attributes;
    assign o_first_cluster    = r_res.first_cluster;
    assign o_file_size        = r_res.file_size;
    assign o_modified_date    = r_res.modified_date;
    assign o_modified_time    = r_res.modified_time;
    assign o_lfn_sequence     = r_res.lfn_sequence;
    assign o_lfn_is_last      = r_res.lfn_is_last;

endmodule

// File: dv/fat_directory_entry_scanner_tb.sv
// ----------------------------------------------------------------------------
// fat_directory_entry_scanner_tb
// Streams directory bytes into the scanner and checks every decoded entry.
// ----------------------------------------------------------------------------
// A scoreboard collects each accepted byte into its own copy of the entry
// buffer. At the last byte of an entry it decodes the expected result, and it
// compares that result field by field with what the scanner returns. The
// stimulus opens with hand-built entries for the corner cases. It then holds
// the output side off for a long stretch so that the scanner fills up. Random
// directory streams follow under several idle and stall mixes; they hold
// partial entries, stray restarts and junk after an end-of-directory entry.
// ----------------------------------------------------------------------------
module fat_directory_entry_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 250;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_BYTES  = 200;
    localparam int MAX_GAP      = 60;
    localparam int IDLE_SET[4]  = '{0, 78, 0, 23};
    localparam int STALL_SET[4] = '{0, 0, 78, 23};

    class entry_scoreboard;
        bit [4:0]          byte_pos;
        bit                scan_ended;
        fdes_pkg::t_entry  entry_buf;
        fdes_pkg::t_result pending_entries[$];
        int                taken;
        int                errors;

        function fdes_pkg::t_result decode_entry(fdes_pkg::t_entry e);
            fdes_pkg::t_result r;
            int                n;
            r = '0;
            if (e[0] == fdes_pkg::BYTE_END) begin
                r.entry_kind = fdes_pkg::KIND_END;
            end else if (e[0] == fdes_pkg::BYTE_DELETED) begin
                r.entry_kind = fdes_pkg::KIND_DELETED;
            end else if ((e[fdes_pkg::OFS_ATTR] & fdes_pkg::ATTR_LFN_MASK)
                         == fdes_pkg::ATTR_LFN) begin
                r.entry_kind = fdes_pkg::KIND_LFN;
            end else if (e[0] == fdes_pkg::BYTE_DOT) begin
                r.entry_kind = fdes_pkg::KIND_DOT;
            end else begin
                r.entry_kind = fdes_pkg::KIND_SHORT;
            end
            for (int i = 0; i < fdes_pkg::NAME_BYTES; i++) r.short_name[8*i +: 8] = e[i];
            for (int i = 0; i < fdes_pkg::EXT_BYTES; i++) begin
                r.extension[8*i +: 8] = e[fdes_pkg::NAME_BYTES + i];
            end
            n = fdes_pkg::NAME_BYTES;
            while (n > 0 && e[n-1] == fdes_pkg::BYTE_SPACE) n--;
            r.name_length = 4'(n);
            n = fdes_pkg::EXT_BYTES;
            while (n > 0 && e[fdes_pkg::NAME_BYTES + n - 1] == fdes_pkg::BYTE_SPACE) n--;
            r.extension_length = 2'(n);
            r.attributes    = e[fdes_pkg::OFS_ATTR];
            r.first_cluster = {e[fdes_pkg::OFS_CLUS_HI+1], e[fdes_pkg::OFS_CLUS_HI],
                               e[fdes_pkg::OFS_CLUS_LO+1], e[fdes_pkg::OFS_CLUS_LO]};
            r.file_size     = {e[fdes_pkg::OFS_SIZE+3], e[fdes_pkg::OFS_SIZE+2],
                               e[fdes_pkg::OFS_SIZE+1], e[fdes_pkg::OFS_SIZE]};
            r.modified_date = {e[fdes_pkg::OFS_DATE+1], e[fdes_pkg::OFS_DATE]};
            r.modified_time = {e[fdes_pkg::OFS_TIME+1], e[fdes_pkg::OFS_TIME]};
            if (r.entry_kind == fdes_pkg::KIND_LFN) begin
                r.lfn_sequence = e[0][4:0] & fdes_pkg::LFN_SEQ_MASK[4:0];
                r.lfn_is_last  = e[0][fdes_pkg::LFN_LAST_BIT];
            end
            return r;
        endfunction

        function void take_byte(logic [7:0] b, logic rs);
            fdes_pkg::t_result r;
            if (rs) begin
                byte_pos   = '0;
                scan_ended = 1'b0;
            end
            // Bytes after an end-of-directory entry are dropped until a restart.
            if (scan_ended) return;
            taken++;
            entry_buf[byte_pos] = b;
            if (byte_pos == 5'd31) begin
                r = decode_entry(entry_buf);
                pending_entries.push_back(r);
                if (r.entry_kind == fdes_pkg::KIND_END) scan_ended = 1'b1;
            end
            byte_pos = byte_pos + 5'd1;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 40) $display("scanner mismatch: %s got %0h want %0h", what, got, want);
        endtask

        task check_field(string what, logic [63:0] got, logic [63:0] want);
            if (got !== want) report(what, got, want);
        endtask

        task check_entry(fdes_pkg::t_result got);
            fdes_pkg::t_result want;
            if (pending_entries.size() == 0) begin
                report("result with no entry pending", 64'(got.entry_kind), '0);
                return;
            end
            want = pending_entries.pop_front();
            check_field("entry_kind", got.entry_kind, want.entry_kind);
            check_field("short_name", got.short_name, want.short_name);
            check_field("name_length", got.name_length, want.name_length);
            check_field("extension", got.extension, want.extension);
            check_field("extension_length", got.extension_length, want.extension_length);
            check_field("attributes", got.attributes, want.attributes);
            check_field("first_cluster", got.first_cluster, want.first_cluster);
            check_field("file_size", got.file_size, want.file_size);
            check_field("modified_date", got.modified_date, want.modified_date);
            check_field("modified_time", got.modified_time, want.modified_time);
            check_field("lfn_sequence", got.lfn_sequence, want.lfn_sequence);
            check_field("lfn_is_last", got.lfn_is_last, want.lfn_is_last);
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [7:0]        i_data_byte = '0;
    logic              i_restart = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [2:0]        o_entry_kind;
    logic [63:0]       o_short_name;
    logic [3:0]        o_name_length;
    logic [23:0]       o_extension;
    logic [1:0]        o_extension_length;
    logic [7:0]        o_attributes;
    logic [31:0]       o_first_cluster;
    logic [31:0]       o_file_size;
    logic [15:0]       o_modified_date;
    logic [15:0]       o_modified_time;
    logic [4:0]        o_lfn_sequence;
    logic              o_lfn_is_last;
    fdes_pkg::t_result seen;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet = 0;
    bit need_restart = 1'b0;
    bit after_end = 1'b0;

    entry_scoreboard sb = new;

    fat_directory_entry_scanner DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .i_restart          (i_restart),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_entry_kind       (o_entry_kind),
        .o_short_name       (o_short_name),
        .o_name_length      (o_name_length),
        .o_extension        (o_extension),
        .o_extension_length (o_extension_length),
        .o_attributes       (o_attributes),
        .o_first_cluster    (o_first_cluster),
        .o_file_size        (o_file_size),
        .o_modified_date    (o_modified_date),
        .o_modified_time    (o_modified_time),
        .o_lfn_sequence     (o_lfn_sequence),
        .o_lfn_is_last      (o_lfn_is_last)
    );

    assign seen = {o_entry_kind, o_short_name, o_name_length, o_extension,
                   o_extension_length, o_attributes, o_first_cluster, o_file_size,
                   o_modified_date, o_modified_time, o_lfn_sequence, o_lfn_is_last};

    always #6 i_clk = ~i_clk;

    // Output side: random stalls, or a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.take_byte(i_data_byte, i_restart);
            if (o_valid && !i_stall) sb.check_entry(seen);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet == QUIET_LIMIT) begin
            $display("fat_directory_entry_scanner_tb: errors");
            $finish;
        end
    end

    function automatic fdes_pkg::t_entry make_entry(fdes_pkg::t_kind kind, bit shaped);
        fdes_pkg::t_entry e;
        int               nlen;
        int               elen;
        for (int i = 0; i < fdes_pkg::ENTRY_BYTES; i++) e[i] = 8'($urandom_range(255));
        if (!shaped) return e;
        nlen = $urandom_range(fdes_pkg::NAME_BYTES);
        elen = $urandom_range(fdes_pkg::EXT_BYTES);
        for (int i = nlen; i < fdes_pkg::NAME_BYTES; i++) e[i] = fdes_pkg::BYTE_SPACE;
        for (int i = elen; i < fdes_pkg::EXT_BYTES; i++) begin
            e[fdes_pkg::NAME_BYTES + i] = fdes_pkg::BYTE_SPACE;
        end
        case (kind)
            fdes_pkg::KIND_END: e[0] = fdes_pkg::BYTE_END;
            fdes_pkg::KIND_DELETED: e[0] = fdes_pkg::BYTE_DELETED;
            fdes_pkg::KIND_LFN: begin
                if (e[0] == fdes_pkg::BYTE_END || e[0] == fdes_pkg::BYTE_DELETED) begin
                    e[0] ^= 8'h40;
                end
                e[fdes_pkg::OFS_ATTR] = (e[fdes_pkg::OFS_ATTR] & ~fdes_pkg::ATTR_LFN_MASK)
                                        | fdes_pkg::ATTR_LFN;
            end
            default: begin
                if (kind == fdes_pkg::KIND_DOT) begin
                    e[0] = fdes_pkg::BYTE_DOT;
                end else if (e[0] == fdes_pkg::BYTE_END || e[0] == fdes_pkg::BYTE_DELETED
                             || e[0] == fdes_pkg::BYTE_DOT) begin
                    e[0] ^= 8'h01;
                end
                if ((e[fdes_pkg::OFS_ATTR] & fdes_pkg::ATTR_LFN_MASK) == fdes_pkg::ATTR_LFN) begin
                    e[fdes_pkg::OFS_ATTR] ^= 8'h01;
                end
            end
        endcase
        return e;
    endfunction

    // One request per call; valid stays high straight into the next request unless an idle gap is drawn.
    task automatic send_byte(logic [7:0] d, logic rs);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_restart   <= rs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_entry(fdes_pkg::t_entry e, int count, bit rs);
        for (int i = 0; i < count; i++) send_byte(e[i], rs && i == 0);
    endtask

    task automatic random_entry();
        fdes_pkg::t_entry e;
        fdes_pkg::t_kind  kind;
        int               pick;
        if (after_end) begin
            repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)), 1'b0);
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            e = make_entry(fdes_pkg::KIND_SHORT, 1'b0);
            send_entry(e, 32, need_restart);
            after_end = (e[0] == fdes_pkg::BYTE_END);
            need_restart = after_end;
        end else if (pick < 20) begin
            // Broken entry: cut short and followed by a restart.
            e = make_entry(fdes_pkg::KIND_SHORT, 1'b1);
            send_entry(e, $urandom_range(1, 31), need_restart);
            after_end = 1'b0;
            need_restart = 1'b1;
        end else begin
            pick = $urandom_range(99);
            if (pick < 45) kind = fdes_pkg::KIND_SHORT;
            else if (pick < 60) kind = fdes_pkg::KIND_DELETED;
            else if (pick < 82) kind = fdes_pkg::KIND_LFN;
            else if (pick < 95) kind = fdes_pkg::KIND_DOT;
            else kind = fdes_pkg::KIND_END;
            e = make_entry(kind, 1'b1);
            send_entry(e, 32, need_restart || $urandom_range(19) == 0);
            after_end = (kind == fdes_pkg::KIND_END);
            need_restart = after_end;
        end
    endtask

    initial begin
        fdes_pkg::t_entry e;
        int               goal;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every field at its maximum.
        e = '1;
        send_entry(e, 32, 1'b0);
        // One-letter name, empty extension, all other fields zero.
        e = '0;
        e[0] = 8'h41;
        for (int i = 1; i < 11; i++) e[i] = fdes_pkg::BYTE_SPACE;
        send_entry(e, 32, 1'b0);
        // Blank name: a space in the first byte is a plain short entry.
        e = {fdes_pkg::ENTRY_BYTES{fdes_pkg::BYTE_SPACE}};
        send_entry(e, 32, 1'b0);
        // Inner spaces count toward the length; a leading 0x05 is not special.
        e = make_entry(fdes_pkg::KIND_SHORT, 1'b1);
        e[0] = 8'h05;
        e[1] = fdes_pkg::BYTE_SPACE;
        e[2] = 8'h42;
        for (int i = 3; i < 9; i++) e[i] = fdes_pkg::BYTE_SPACE;
        e[9]  = 8'h43;
        e[10] = fdes_pkg::BYTE_SPACE;
        e[fdes_pkg::OFS_ATTR] = 8'h10;
        send_entry(e, 32, 1'b0);
        // A deleted marker wins over long-name attributes.
        e = make_entry(fdes_pkg::KIND_DELETED, 1'b1);
        e[fdes_pkg::OFS_ATTR] = fdes_pkg::ATTR_LFN;
        send_entry(e, 32, 1'b0);
        e = make_entry(fdes_pkg::KIND_LFN, 1'b1);
        e[0] = 8'h41;
        send_entry(e, 32, 1'b0);
        e = make_entry(fdes_pkg::KIND_LFN, 1'b1);
        e[0] = 8'h9F;
        e[fdes_pkg::OFS_ATTR] = 8'hCF;
        send_entry(e, 32, 1'b0);
        // Long-name attributes win over a dot in the first byte.
        e = make_entry(fdes_pkg::KIND_LFN, 1'b1);
        e[0] = fdes_pkg::BYTE_DOT;
        send_entry(e, 32, 1'b0);
        e = {fdes_pkg::ENTRY_BYTES{fdes_pkg::BYTE_SPACE}};
        e[0] = fdes_pkg::BYTE_DOT;
        e[1] = fdes_pkg::BYTE_DOT;
        e[fdes_pkg::OFS_ATTR] = 8'h10;
        send_entry(e, 32, 1'b0);
        // Partial entry abandoned by a restart.
        send_entry(make_entry(fdes_pkg::KIND_SHORT, 1'b1), 7, 1'b0);
        send_entry(make_entry(fdes_pkg::KIND_DOT, 1'b1), 32, 1'b1);
        // End of directory wins over long-name attributes; junk after it is dropped.
        e = make_entry(fdes_pkg::KIND_END, 1'b1);
        e[fdes_pkg::OFS_ATTR] = fdes_pkg::ATTR_LFN;
        send_entry(e, 32, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hE5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_entry(make_entry(fdes_pkg::KIND_SHORT, 1'b1), 32, 1'b1);

        // Hold the output side off while the input keeps coming.
        hold_token = hold_token + 1;
        repeat (4) send_entry(make_entry(fdes_pkg::KIND_SHORT, 1'b1), 32, 1'b0);

        for (int p = 0; p < 4; p++) begin
            idle_pct  = IDLE_SET[p];
            stall_pct = STALL_SET[p];
            goal = sb.taken + PHASE_BYTES;
            while (sb.taken < goal) random_entry();
        end
        i_valid <= 1'b0;
        stall_pct = 0;

        // Let the last accepted byte reach the scoreboard before draining.
        repeat (2) @(posedge i_clk);
        while (sb.pending_entries.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_entries.size() == 0) begin
            $display("fat_directory_entry_scanner_tb: clean");
        end else begin
            $display("fat_directory_entry_scanner_tb: errors");
        end
        $finish;
    end

endmodule
